[hw/rtl/median_sigma_clip_cleaner_defines.svh]
// Assertion macros for the channel cleaner.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MEDIAN_SIGMA_CLIP_CLEANER_DEFINES_SVH
`define MEDIAN_SIGMA_CLIP_CLEANER_DEFINES_SVH

// Same-cycle implication
`define MSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/msc_pkg.sv]
// Shared widths, codes and reset values of the channel cleaner.
// No dependencies.
`default_nettype none
package msc_pkg;
  localparam int CHANNEL_SAMPLES_DEF = 1024;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 15;
  localparam int MED_W    = 17;
  localparam int DEV_W    = 20;
  localparam int TF_W     = 8;
  localparam int ACC_W    = 48;   // sum of squared deviations
  localparam int DVD_W    = 54;   // sum * 64
  localparam int ROOT_W   = 27;
  localparam int SQ_W     = 34;
  localparam int THR_W    = 29;

  localparam logic [TF_W-1:0]  TF_RESET = 8'd72;   // 4.5 in Q4.4
  localparam logic [DEV_W-1:0] DEV_MAX  = 20'hFFFFF;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
endpackage
`default_nettype wire

[hw/rtl/msc_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on msc_pkg.
`default_nettype none
module msc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [msc_pkg::DVD_W-1:0] dividend,
  input  wire logic [msc_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [msc_pkg::DVD_W-1:0]      quotient
);
  import msc_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, q_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // shift one dividend bit into the remainder, subtract when it fits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dsr_r});
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

[hw/rtl/msc_root.sv]
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on msc_pkg.
`default_nettype none
module msc_root (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [msc_pkg::DVD_W-1:0] radicand,
  output logic                           done,
  output logic [msc_pkg::ROOT_W-1:0]     root
);
  import msc_pkg::*;

  localparam logic [DVD_W-1:0] BIT_INIT = DVD_W'(1) << (DVD_W - 2);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVD_W-1:0] v_r, v_nxt;
  logic [DVD_W-1:0] r_r, r_nxt;
  logic [DVD_W-1:0] bit_r, bit_nxt;
  logic [DVD_W-1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    trial    = r_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = radicand;
      r_nxt    = '0;
      bit_nxt  = BIT_INIT;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];
endmodule
`default_nettype wire

[hw/rtl/median_sigma_clip_cleaner.sv]
// Load: the input never stalls while samples are loaded. After the last sample
// the statistics make 16 radix-select passes over the sample RAM and one
// sum-of-squares pass, then run the serial divider and serial square root.
// Drain: RAM read, then compare into output register, before the next is accepted.
// Reset is synchronous active low and clears control; the sample RAM is not cleared.
// Top level of the channel cleaner; depends on msc_pkg, msc_div, msc_root.
`default_nettype none
`include "median_sigma_clip_cleaner_defines.svh"
module median_sigma_clip_cleaner #(
  parameter int CHANNEL_SAMPLES = msc_pkg::CHANNEL_SAMPLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [msc_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [msc_pkg::MED_W-1:0]         out_cleaned,
  output logic                              out_replaced,
  output logic [msc_pkg::MED_W-1:0]         out_channel_median,
  output logic [msc_pkg::DEV_W-1:0]         out_channel_deviation,
  output logic [msc_pkg::CNT_W-1:0]         out_replaced_count,
  output logic                              out_run_end,
  input  wire logic                         cfg_wr_en,
  input  wire logic [msc_pkg::TF_W-1:0]     cfg_wr_data
);
  import msc_pkg::*;

  localparam int AW = $clog2(CHANNEL_SAMPLES);

  typedef enum logic [2:0] {
    ST_LOAD, ST_SEL, ST_SQ, ST_DIV, ST_ROOT, ST_DRAIN, ST_FETCH
  } state_t;

  state_t              st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    rdpos_r, rdpos_nxt;
  logic                rv_r, rv_nxt;
  logic [3:0]          bit_r, bit_nxt;
  logic [SAMPLE_W-1:0] pfx1_r, pfx1_nxt, pfx2_r, pfx2_nxt;
  logic [CNT_W-1:0]    k1_r, k1_nxt, k2_r, k2_nxt;
  logic [CNT_W-1:0]    c1_r, c1_nxt, c2_r, c2_nxt;
  logic [MED_W-1:0]    d_r, d_nxt;
  logic                dv_r, dv_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic                sv_r, sv_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [MED_W-1:0]    med_r, med_nxt;
  logic [DEV_W-1:0]    dev_r, dev_nxt;
  logic [CNT_W-1:0]    tally_r, tally_nxt;
  logic [TF_W-1:0]     tf_r, tf_nxt;
  logic                ov_r, ov_nxt;
  logic [MED_W-1:0]    oclean_r, oclean_nxt;
  logic                orep_r, orep_nxt;
  logic [MED_W-1:0]    omed_r, omed_nxt;
  logic [DEV_W-1:0]    odev_r, odev_nxt;
  logic [CNT_W-1:0]    ocnt_r, ocnt_nxt;
  logic                oend_r, oend_nxt;

  logic [SAMPLE_W-1:0] mem [CHANNEL_SAMPLES];
  logic [SAMPLE_W-1:0] rd_q;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  logic                in_acc;
  logic                div_start, div_done, root_start, root_done;
  logic [DVD_W-1:0]    quot;
  logic [ROOT_W-1:0]   root_val;

  // scratch values of the sequencer
  logic [CNT_W-1:0]    cnt_new;
  logic                m1, m2;
  logic [SAMPLE_W-1:0] p1_fin, p2_fin;
  logic [MED_W-1:0]    x2;
  logic [THR_W-1:0]    lhs, rhs;
  logic                rep;
  logic [CNT_W-1:0]    pos1, tally_inc;

  assign in_stall = !(st_r == ST_LOAD || (st_r == ST_DRAIN && !(ov_r && out_stall)));
  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = in_acc && st_r == ST_LOAD && in_kind == KIND_LOAD &&
                    cnt_r < CNT_W'(CHANNEL_SAMPLES);
  assign rd_addr  = (st_r == ST_DRAIN) ? rdpos_r[AW-1:0] : idx_r[AW-1:0];

  // sample RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= in_sample;
    end
    rd_q <= mem[rd_addr];
  end

  msc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({acc_r, 6'b0}), .divisor(CNT_W'(cnt_r - 1'b1)),
    .done(div_done), .quotient(quot)
  );

  msc_root u_root (
    .clk(clk), .rst_n(rst_n), .start(root_start),
    .radicand(quot), .done(root_done), .root(root_val)
  );

  // sequencer
  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    rdpos_nxt  = rdpos_r;
    rv_nxt     = 1'b0;
    bit_nxt    = bit_r;
    pfx1_nxt   = pfx1_r;
    pfx2_nxt   = pfx2_r;
    k1_nxt     = k1_r;
    k2_nxt     = k2_r;
    c1_nxt     = c1_r;
    c2_nxt     = c2_r;
    d_nxt      = d_r;
    dv_nxt     = 1'b0;
    sq_nxt     = sq_r;
    sv_nxt     = 1'b0;
    acc_nxt    = acc_r;
    med_nxt    = med_r;
    dev_nxt    = dev_r;
    tally_nxt  = tally_r;
    tf_nxt     = cfg_wr_en ? cfg_wr_data : tf_r;
    ov_nxt     = ov_r && out_stall;
    oclean_nxt = oclean_r;
    orep_nxt   = orep_r;
    omed_nxt   = omed_r;
    odev_nxt   = odev_r;
    ocnt_nxt   = ocnt_r;
    oend_nxt   = oend_r;
    div_start  = 1'b0;
    root_start = 1'b0;

    cnt_new   = cnt_r + CNT_W'(mem_we);
    m1        = (rd_q >> bit_r) == (pfx1_r >> bit_r);
    m2        = (rd_q >> bit_r) == (pfx2_r >> bit_r);
    p1_fin    = (k1_r < c1_r) ? pfx1_r : (pfx1_r | (SAMPLE_W'(1) << bit_r));
    p2_fin    = (k2_r < c2_r) ? pfx2_r : (pfx2_r | (SAMPLE_W'(1) << bit_r));
    x2        = {rd_q, 1'b0};
    lhs       = THR_W'({rd_q, 8'b0});
    rhs       = THR_W'(tf_r) * THR_W'(dev_r) + THR_W'({med_r, 7'b0});
    rep       = lhs > rhs;
    pos1      = rdpos_r + 1'b1;
    tally_inc = tally_r + CNT_W'(rep);

    case (st_r)
      ST_LOAD: begin
        if (in_acc && in_kind == KIND_LOAD) begin
          cnt_nxt = cnt_new;
          if (in_last) begin
            // set up both order statistics; equal for an odd count
            st_nxt   = ST_SEL;
            idx_nxt  = '0;
            bit_nxt  = 4'd15;
            pfx1_nxt = '0;
            pfx2_nxt = '0;
            c1_nxt   = '0;
            c2_nxt   = '0;
            k2_nxt   = cnt_new >> 1;
            k1_nxt   = cnt_new[0] ? (cnt_new >> 1) : CNT_W'((cnt_new >> 1) - 1'b1);
          end
        end
      end
      ST_SEL: begin
        // radix select: count candidates with this bit clear
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + 1'b1;
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          c1_nxt = c1_r + CNT_W'(m1);
          c2_nxt = c2_r + CNT_W'(m2);
        end
        if (idx_r >= cnt_r && !rv_r) begin
          pfx1_nxt = p1_fin;
          pfx2_nxt = p2_fin;
          if (k1_r >= c1_r) k1_nxt = k1_r - c1_r;
          if (k2_r >= c2_r) k2_nxt = k2_r - c2_r;
          c1_nxt  = '0;
          c2_nxt  = '0;
          idx_nxt = '0;
          if (bit_r == 4'd0) begin
            st_nxt  = ST_SQ;
            med_nxt = MED_W'(p1_fin) + MED_W'(p2_fin);
            acc_nxt = '0;
          end else begin
            bit_nxt = bit_r - 1'b1;
          end
        end
      end
      ST_SQ: begin
        // read, difference, square, accumulate
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + 1'b1;
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          d_nxt  = (x2 >= med_r) ? x2 - med_r : med_r - x2;
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          sq_nxt = SQ_W'(d_r) * SQ_W'(d_r);
          sv_nxt = 1'b1;
        end
        if (sv_r) begin
          acc_nxt = acc_r + ACC_W'(sq_r);
        end
        if (idx_r >= cnt_r && !rv_r && !dv_r && !sv_r) begin
          if (cnt_r < CNT_W'(2)) begin
            dev_nxt   = '0;
            st_nxt    = ST_DRAIN;
            rdpos_nxt = '0;
            tally_nxt = '0;
          end else begin
            div_start = 1'b1;
            st_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          root_start = 1'b1;
          st_nxt     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          dev_nxt   = (root_val > ROOT_W'(DEV_MAX)) ? DEV_MAX : root_val[DEV_W-1:0];
          st_nxt    = ST_DRAIN;
          rdpos_nxt = '0;
          tally_nxt = '0;
        end
      end
      ST_DRAIN: begin
        if (in_acc && in_kind == KIND_DRAIN) begin
          st_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // threshold compare and output transaction
        ov_nxt     = 1'b1;
        oclean_nxt = rep ? med_r : x2;
        orep_nxt   = rep;
        omed_nxt   = med_r;
        odev_nxt   = dev_r;
        tally_nxt  = tally_inc;
        oend_nxt   = pos1 >= cnt_r;
        ocnt_nxt   = (pos1 >= cnt_r) ? tally_inc : '0;
        if (pos1 >= cnt_r) begin
          st_nxt    = ST_LOAD;
          cnt_nxt   = '0;
          rdpos_nxt = '0;
        end else begin
          st_nxt    = ST_DRAIN;
          rdpos_nxt = pos1;
        end
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
      rdpos_r <= '0;
      rv_r    <= 1'b0;
      dv_r    <= 1'b0;
      sv_r    <= 1'b0;
      med_r   <= '0;
      dev_r   <= '0;
      tally_r <= '0;
      tf_r    <= TF_RESET;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      rdpos_r <= rdpos_nxt;
      rv_r    <= rv_nxt;
      dv_r    <= dv_nxt;
      sv_r    <= sv_nxt;
      med_r   <= med_nxt;
      dev_r   <= dev_nxt;
      tally_r <= tally_nxt;
      tf_r    <= tf_nxt;
      ov_r    <= ov_nxt;
    end
    bit_r    <= bit_nxt;
    pfx1_r   <= pfx1_nxt;
    pfx2_r   <= pfx2_nxt;
    k1_r     <= k1_nxt;
    k2_r     <= k2_nxt;
    c1_r     <= c1_nxt;
    c2_r     <= c2_nxt;
    d_r      <= d_nxt;
    sq_r     <= sq_nxt;
    acc_r    <= acc_nxt;
    oclean_r <= oclean_nxt;
    orep_r   <= orep_nxt;
    omed_r   <= omed_nxt;
    odev_r   <= odev_nxt;
    ocnt_r   <= ocnt_nxt;
    oend_r   <= oend_nxt;
  end

  assign out_valid             = ov_r;
  assign out_cleaned           = oclean_r;
  assign out_replaced          = orep_r;
  assign out_channel_median    = omed_r;
  assign out_channel_deviation = odev_r;
  assign out_replaced_count    = ocnt_r;
  assign out_run_end           = oend_r;

  // checks
  `MSC_ASSERT_SAME(a_accept_idle, in_acc, st_r == ST_LOAD || st_r == ST_DRAIN, "accept while busy")
  `MSC_ASSERT_NEXT(a_fetch_out, st_r == ST_FETCH, ov_r, "fetch did not produce a transaction")
  `MSC_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CHANNEL_SAMPLES), "stored count overflow")
  `MSC_ASSERT_SAME(a_rdpos_bound, st_r == ST_DRAIN, rdpos_r < cnt_r, "drain position past count")
endmodule
`default_nettype wire

[bench/median_sigma_clip_cleaner_test.sv]
// Self-checking testbench for median_sigma_clip_cleaner: directed table, random channels, then a full store.
// Depends on msc_pkg and the cleaner RTL; carries its own channel statistics predictor.
module median_sigma_clip_cleaner_test;
  import msc_pkg::*;

  typedef struct packed {
    logic [MED_W-1:0]  cleaned;
    logic              replaced;
    logic [MED_W-1:0]  median;
    logic [DEV_W-1:0]  deviation;
    logic [CNT_W-1:0]  count;
    logic              run_end;
  } clean_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t           op;
    logic              kind;
    logic [SAMPLE_W-1:0] sample;
    logic              mark;
    logic [TF_W-1:0]   factor;
    bit                typed;
    clean_res_t        res;
  } stim_row_t;

  localparam int STORE_DEPTH  = CHANNEL_SAMPLES_DEF;
  localparam int SETTLE_CYC   = 40;
  localparam int RANDOM_ITEMS = 780;
  localparam int FULL_DRAINS  = 16;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_kind;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_last;
  logic                out_valid;
  logic                out_stall;
  logic [MED_W-1:0]    out_cleaned;
  logic                out_replaced;
  logic [MED_W-1:0]    out_channel_median;
  logic [DEV_W-1:0]    out_channel_deviation;
  logic [CNT_W-1:0]    out_replaced_count;
  logic                out_run_end;
  logic                cfg_wr_en;
  logic [TF_W-1:0]     cfg_wr_data;

  median_sigma_clip_cleaner u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_sample(in_sample), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_cleaned(out_cleaned),
    .out_replaced(out_replaced), .out_channel_median(out_channel_median),
    .out_channel_deviation(out_channel_deviation),
    .out_replaced_count(out_replaced_count), .out_run_end(out_run_end),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state
  logic [SAMPLE_W-1:0] chan_store [STORE_DEPTH];
  int unsigned         chan_count;
  int unsigned         chan_rd;
  logic [MED_W-1:0]    chan_median;
  logic [DEV_W-1:0]    chan_dev;
  logic [CNT_W-1:0]    chan_tally;
  bit                  chan_draining;
  logic [TF_W-1:0]     clip_factor;

  clean_res_t  cleaned_q [$];
  stim_row_t   dir_rows [$];
  int          idle_in_pct;
  int          idle_out_pct;
  int          hold_left;
  int          mismatches;
  int          results_seen;
  int          replaced_seen;
  int          channels_done;
  int          items_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("median_sigma_clip_cleaner_test: FAIL");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Median and deviation of the stored channel
  task automatic channel_stats();
    int unsigned     vals [];
    longint unsigned sumsq;
    longint unsigned x2;
    longint unsigned d;
    longint unsigned root;
    int unsigned     n;
    n = chan_count;
    vals = new[n];
    for (int i = 0; i < n; i++) vals[i] = chan_store[i];
    vals.sort();
    if (n % 2) chan_median = MED_W'(2 * vals[n/2]);
    else chan_median = MED_W'(vals[n/2-1] + vals[n/2]);
    sumsq = 0;
    for (int i = 0; i < n; i++) begin
      x2 = 2 * longint'(chan_store[i]);
      d = (x2 >= chan_median) ? x2 - chan_median : chan_median - x2;
      sumsq += d * d;
    end
    if (n < 2) begin
      chan_dev = '0;
    end else begin
      root = int_sqrt((sumsq * 64) / (n - 1));
      chan_dev = (root > DEV_MAX) ? DEV_MAX : root[DEV_W-1:0];
    end
  endtask

  // One accepted transaction through the predictor
  task automatic predict_clean(input logic kind, input logic [SAMPLE_W-1:0] smp,
                               input logic mark, output bit got, output clean_res_t r);
    longint unsigned x;
    longint unsigned lhs;
    longint unsigned rhs;
    bit rep;
    bit fin;
    got = 0;
    r = '0;
    if (!chan_draining) begin
      if (kind == KIND_LOAD) begin
        if (chan_count < STORE_DEPTH) begin
          chan_store[chan_count] = smp;
          chan_count++;
        end
        if (mark) begin
          channel_stats();
          chan_rd = 0;
          chan_tally = '0;
          chan_draining = 1;
        end
      end
    end else if (kind == KIND_DRAIN) begin
      x = (chan_rd < chan_count) ? chan_store[chan_rd] : 0;
      lhs = x << 8;
      rhs = longint'(clip_factor) * chan_dev + (longint'(chan_median) << 7);
      rep = lhs > rhs;
      if (rep) chan_tally++;
      chan_rd++;
      fin = chan_rd >= chan_count;
      r.cleaned   = rep ? chan_median : MED_W'(2 * x);
      r.replaced  = rep;
      r.median    = chan_median;
      r.deviation = chan_dev;
      r.count     = fin ? chan_tally : '0;
      r.run_end   = fin;
      got = 1;
      if (fin) begin
        chan_draining = 0;
        chan_count = 0;
        chan_rd = 0;
      end
    end
  endtask

  // Offer one transaction, wait for acceptance, then predict
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp,
                           input logic mark, input bit typed, input clean_res_t tres);
    bit         got;
    clean_res_t r;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= smp;
    in_last   <= mark;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    items_sent++;
    predict_clean(kind, smp, mark, got, r);
    if (got) cleaned_q.insert(cleaned_q.size(), typed ? tres : r);
  endtask

  // Append one row to the directed table
  task automatic add_row(input stim_row_t s);
    dir_rows.insert(dir_rows.size(), s);
  endtask

  // Let every expected result arrive, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cleaned_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_factor(input logic [TF_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clip_factor = v;
  endtask

  function automatic stim_row_t item_row(logic kind, logic [SAMPLE_W-1:0] smp, logic mark);
    stim_row_t s;
    s = '{op: ROW_ITEM, kind: kind, sample: smp, mark: mark, factor: '0,
          typed: 0, res: '0};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [TF_W-1:0] v);
    stim_row_t s;
    s = item_row(KIND_LOAD, '0, 1'b0);
    s.op = ROW_CFG;
    s.factor = v;
    return s;
  endfunction

  // Random sample around a channel level, with occasional spikes
  function automatic logic [SAMPLE_W-1:0] gen_sample(int unsigned level, int unsigned spread);
    int unsigned roll;
    longint v;
    roll = $urandom_range(99);
    if (roll < 5) return SAMPLE_W'($urandom);
    if (roll < 15) v = level + spread * $urandom_range(5, 40) + $urandom_range(200);
    else v = longint'(level) + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  // One random channel: loads then drains, with some noise transactions
  task automatic send_channel(input int unsigned n, input bit noisy, input int hold);
    int unsigned level;
    int unsigned spread;
    level  = $urandom_range(65535);
    spread = ($urandom_range(3) == 0) ? $urandom_range(4000) : $urandom_range(60);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(KIND_DRAIN, SAMPLE_W'($urandom), 1'($urandom), 0, '0);
      send_item(KIND_LOAD, gen_sample(level, spread), i == n - 1, 0, '0);
    end
    if (hold > 0) hold_left = hold;
    for (int i = 0; i < n && i < STORE_DEPTH; i++) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(KIND_LOAD, SAMPLE_W'($urandom), 1'($urandom), 0, '0);
      send_item(KIND_DRAIN, SAMPLE_W'($urandom), 1'($urandom), 0, '0);
    end
    channels_done++;
  endtask

  // Result checker and stall generator
  initial begin
    clean_res_t got_r;
    clean_res_t exp_r;
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got_r = '{out_cleaned, out_replaced, out_channel_median, out_channel_deviation,
                  out_replaced_count, out_run_end};
        results_seen++;
        if (out_replaced) replaced_seen++;
        if (cleaned_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", got_r);
        end else begin
          exp_r = cleaned_q.pop_front();
          if (got_r.cleaned !== exp_r.cleaned || got_r.replaced !== exp_r.replaced ||
              got_r.median !== exp_r.median || got_r.deviation !== exp_r.deviation ||
              got_r.count !== exp_r.count || got_r.run_end !== exp_r.run_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0b/%0d/%0d/%0d/%0b got %0d/%0b/%0d/%0d/%0d/%0b",
                       exp_r.cleaned, exp_r.replaced, exp_r.median, exp_r.deviation,
                       exp_r.count, exp_r.run_end, got_r.cleaned, got_r.replaced,
                       got_r.median, got_r.deviation, got_r.count, got_r.run_end);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_out_pct);
      end
    end
  end

  // Main sequence
  initial begin
    stim_row_t  row;
    bit         pressed;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= KIND_LOAD;
    in_sample   <= '0;
    in_last     <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    idle_in_pct = 25;
    idle_out_pct = 52;
    hold_left = 0;
    mismatches = 0;
    results_seen = 0;
    replaced_seen = 0;
    channels_done = 0;
    items_sent = 0;
    pressed = 0;
    chan_count = 0;
    chan_rd = 0;
    chan_median = '0;
    chan_dev = '0;
    chan_tally = '0;
    chan_draining = 0;
    clip_factor = TF_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    add_row(item_row(KIND_DRAIN, 16'hFFFF, 1'b1));   // drain while loading
    add_row(item_row(KIND_LOAD, 16'hFFFF, 1'b1));    // single sample channel
    row = item_row(KIND_DRAIN, 16'h0000, 1'b0);
    row.typed = 1;
    row.res = '{17'd131070, 1'b0, 17'd131070, 20'd0, 15'd0, 1'b1};
    add_row(row);
    add_row(item_row(KIND_LOAD, 16'h0000, 1'b0));
    add_row(item_row(KIND_LOAD, 16'hFFFF, 1'b0));
    add_row(item_row(KIND_LOAD, 16'h0000, 1'b0));
    add_row(item_row(KIND_LOAD, 16'h0000, 1'b1));
    add_row(item_row(KIND_DRAIN, 16'h0000, 1'b0));
    add_row(item_row(KIND_LOAD, 16'h1234, 1'b1));    // load while draining
    add_row(item_row(KIND_DRAIN, 16'hFFFF, 1'b1));
    add_row(item_row(KIND_DRAIN, 16'h0000, 1'b0));
    add_row(item_row(KIND_DRAIN, 16'h0000, 1'b0));
    add_row(cfg_row(8'd0));                          // zero factor: clip at median
    add_row(item_row(KIND_LOAD, 16'd100, 1'b0));
    add_row(item_row(KIND_LOAD, 16'd100, 1'b0));
    add_row(item_row(KIND_LOAD, 16'd100, 1'b0));
    add_row(item_row(KIND_LOAD, 16'd5000, 1'b1));
    for (int i = 0; i < 4; i++) add_row(item_row(KIND_DRAIN, 16'h0000, 1'b0));
    add_row(cfg_row(8'd255));
    add_row(item_row(KIND_LOAD, 16'd0, 1'b0));
    add_row(item_row(KIND_LOAD, 16'd65535, 1'b1));
    add_row(item_row(KIND_DRAIN, 16'h0000, 1'b0));
    add_row(item_row(KIND_DRAIN, 16'h0000, 1'b0));
    add_row(cfg_row(TF_RESET));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) write_factor(dir_rows[i].factor);
      else send_item(dir_rows[i].kind, dir_rows[i].sample, dir_rows[i].mark,
                     dir_rows[i].typed, dir_rows[i].res);
    end

    // Random channels in three idle settings
    items_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct  = (ph == 0) ? 25 : (ph == 1) ? 52 : 0;
      idle_out_pct = (ph == 0) ? 52 : (ph == 1) ? 25 : 0;
      while (items_sent < RANDOM_ITEMS * (ph + 1) / 3) begin
        case ($urandom_range(9))
          0: write_factor(TF_W'($urandom));
          1: write_factor(($urandom_range(1)) ? 8'd255 : 8'd0);
          default: ;
        endcase
        if (ph == 1 && !pressed) begin
          // long receiver hold while drains keep coming
          pressed = 1;
          send_channel($urandom_range(8, 24), 0, 400);
        end else if ($urandom_range(19) == 0) send_channel(1, 1, 0);
        else if ($urandom_range(29) == 0) send_channel($urandom_range(60, 200), 1, 0);
        else send_channel($urandom_range(2, 24), $urandom_range(3) == 0, 0);
      end
    end

    // Full store: loads past the depth are dropped, then a few drains
    wait_idle();
    for (int i = 0; i < STORE_DEPTH + 6; i++)
      send_item(KIND_LOAD, gen_sample(30000, 500), i == STORE_DEPTH + 5, 0, '0);
    for (int i = 0; i < FULL_DRAINS; i++) send_item(KIND_DRAIN, '0, 1'b0, 0, '0);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("covered %0d channels, %0d results checked, %0d replaced samples",
             channels_done, results_seen, replaced_seen);
    if (mismatches == 0 && cleaned_q.size() == 0) begin
      $display("median_sigma_clip_cleaner_test: PASS");
    end else begin
      $display("mismatches: %0d, results missing: %0d", mismatches, cleaned_q.size());
      $display("median_sigma_clip_cleaner_test: FAIL");
    end
    $finish;
  end
endmodule

[median_sigma_clip_cleaner.f]
+incdir+hw/rtl
hw/rtl/msc_pkg.sv
hw/rtl/msc_div.sv
hw/rtl/msc_root.sv
hw/rtl/median_sigma_clip_cleaner.sv
bench/median_sigma_clip_cleaner_test.sv
